// File: design/assert_macros.svh
// Concurrent assertion helpers used by taylor_sine_cosine_unit.
// Define SYNTH to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) \
		else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, ck, rn, prop)
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

// File: design/tsc_pkg.sv
package tsc_pkg;

	// angle and result word
	localparam int ANGLE_W = 32;
	// magnitude of internal terms, held within 2^62 - 1
	localparam int MAG_W = 62;
	// signed partial sum
	localparam int SUM_W = MAG_W + 1;
	// reciprocal constants are scaled by 2^RECIP_SHIFT
	localparam int RECIP_SHIFT = 62;

	localparam logic [MAG_W-1:0] MAG_LIMIT = {MAG_W{1'b1}};

	// one item on its way down the term chain
	typedef struct packed {
		logic                    valid;
		logic                    cosine;
		logic                    neg;
		logic [MAG_W-1:0]        mag;
		logic signed [SUM_W-1:0] sum;
	} step_t;

endpackage

// File: design/tsc_mul.sv
module tsc_mul
	import tsc_pkg::*;
#(
	parameter int AW = 62,
	parameter int BW = 62,
	parameter int SH = 62,
	parameter int SW = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             src_valid,
	input  logic [AW-1:0]    src_a,
	input  logic [BW-1:0]    src_b,
	input  logic [SW-1:0]    src_side,
	output logic             res_valid,
	output logic [MAG_W-1:0] res_mag,
	output logic [SW-1:0]    res_side
);

	localparam int HA  = (AW + 1) / 2;
	localparam int A1W = AW - HA;
	localparam int HB  = (BW + 1) / 2;
	localparam int B1W = BW - HB;
	localparam int PW  = AW + BW;
	localparam logic [PW:0] RND       = (PW + 1)'(1) << (SH - 1);
	localparam logic [PW:0] LIMIT_EXT = (PW + 1)'(MAG_LIMIT);

	logic [HA-1:0]  a0;
	logic [A1W-1:0] a1;
	logic [HB-1:0]  b0;
	logic [B1W-1:0] b1;

	logic [HA+HB-1:0]   p00_s1;
	logic [HA+B1W-1:0]  p01_s1;
	logic [A1W+HB-1:0]  p10_s1;
	logic [A1W+B1W-1:0] p11_s1;
	logic [SW-1:0]      side_s1;
	logic               valid_s1;

	logic [AW+HB-1:0]  sa_s2;
	logic [AW+B1W-1:0] sb_s2;
	logic [SW-1:0]     side_s2;
	logic              valid_s2;

	logic [PW:0]        prod;
	logic [PW:0]        shifted;
	logic [MAG_W-1:0]   mag_d;
	logic [MAG_W-1:0]   mag_s3;
	logic [SW-1:0]      side_s3;
	logic               valid_s3;

	assign a0 = src_a[HA-1:0];
	assign a1 = src_a[AW-1:HA];
	assign b0 = src_b[HB-1:0];
	assign b1 = src_b[BW-1:HB];

	// round half away from zero on the magnitude, then saturate
	always_comb begin
		prod    = (PW + 1)'(sa_s2) + (PW + 1)'({sb_s2, {HB{1'b0}}}) + RND;
		shifted = prod >> SH;
		mag_d   = (shifted > LIMIT_EXT) ? MAG_LIMIT : shifted[MAG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= src_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= (HA + HB)'(a0) * (HA + HB)'(b0);
			p01_s1  <= (HA + B1W)'(a0) * (HA + B1W)'(b1);
			p10_s1  <= (A1W + HB)'(a1) * (A1W + HB)'(b0);
			p11_s1  <= (A1W + B1W)'(a1) * (A1W + B1W)'(b1);
			side_s1 <= src_side;

			sa_s2   <= (AW + HB)'(p00_s1) + {p10_s1, {HA{1'b0}}};
			sb_s2   <= (AW + B1W)'(p01_s1) + {p11_s1, {HA{1'b0}}};
			side_s2 <= side_s1;

			mag_s3  <= mag_d;
			side_s3 <= side_s2;
		end
	end

	assign res_valid = valid_s3;
	assign res_mag   = mag_s3;
	assign res_side  = side_s3;

endmodule

// File: design/tsc_term.sv
module tsc_term
	import tsc_pkg::*;
#(
	parameter int K = 1,
	parameter int FRACTION_BITS = 29,
	localparam int X2W = MAG_W + 1 - FRACTION_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  step_t          src,
	input  logic [X2W-1:0] src_x2,
	output step_t          dst,
	output logic [X2W-1:0] dst_x2
);

	localparam int SW = 2 + X2W + SUM_W;
	localparam int M_SIN = 2 * K + 1;
	localparam int M_COS = 2 * K;
	localparam logic [63:0] D_SIN = 64'(M_SIN * (M_SIN - 1));
	localparam logic [63:0] D_COS = 64'(M_COS * (M_COS - 1));
	localparam logic [63:0] RECIP_SIN = ((64'd1 << RECIP_SHIFT) + D_SIN / 2) / D_SIN;
	localparam logic [63:0] RECIP_COS = ((64'd1 << RECIP_SHIFT) + D_COS / 2) / D_COS;
	localparam logic signed [SUM_W:0] LIM = $signed({1'b0, 1'b0, MAG_LIMIT});
	localparam logic signed [SUM_W:0] NLIM = -LIM;

	logic signed [SUM_W:0]   ext_sum;
	logic signed [SUM_W:0]   ext_term;
	logic signed [SUM_W:0]   acc;
	logic signed [SUM_W-1:0] sum_new;
	logic [SW-1:0]           side_in;
	logic                    mid_valid;
	logic [MAG_W-1:0]        mid_mag;
	logic [SW-1:0]           mid_side;
	logic [MAG_W-1:0]        recip;
	logic                    out_valid;
	logic [MAG_W-1:0]        out_mag;
	logic [SW-1:0]           out_side;

	// fold the incoming term into the running sum, saturating
	always_comb begin
		ext_sum  = {src.sum[SUM_W-1], src.sum};
		ext_term = src.neg ? -$signed({2'b00, src.mag}) : $signed({2'b00, src.mag});
		acc      = ext_sum + ext_term;
		if (acc > LIM) begin
			sum_new = LIM[SUM_W-1:0];
		end else if (acc < NLIM) begin
			sum_new = NLIM[SUM_W-1:0];
		end else begin
			sum_new = acc[SUM_W-1:0];
		end
	end

	assign side_in = {src.cosine, src.neg, src_x2, sum_new};

	// term * x^2
	tsc_mul #(
		.AW (MAG_W),
		.BW (X2W),
		.SH (FRACTION_BITS),
		.SW (SW)
	) u_mul_x2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (src.valid),
		.src_a     (src.mag),
		.src_b     (src_x2),
		.src_side  (side_in),
		.res_valid (mid_valid),
		.res_mag   (mid_mag),
		.res_side  (mid_side)
	);

	assign recip = mid_side[SW-1] ? RECIP_COS[MAG_W-1:0] : RECIP_SIN[MAG_W-1:0];

	// divide by m*(m-1) through its reciprocal
	tsc_mul #(
		.AW (MAG_W),
		.BW (MAG_W),
		.SH (RECIP_SHIFT),
		.SW (SW)
	) u_mul_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (mid_valid),
		.src_a     (mid_mag),
		.src_b     (recip),
		.src_side  (mid_side),
		.res_valid (out_valid),
		.res_mag   (out_mag),
		.res_side  (out_side)
	);

	// flip the sign of the new term
	always_comb begin
		dst.valid  = out_valid;
		dst.cosine = out_side[SW-1];
		dst.neg    = !out_side[SW-2];
		dst.mag    = out_mag;
		dst.sum    = out_side[SUM_W-1:0];
		dst_x2     = out_side[SUM_W +: X2W];
	end

endmodule

// File: design/taylor_sine_cosine_unit.sv
// Taylor-series sine / cosine unit. Each request transaction carries an angle in
// signed fixed point (FRACTION_BITS fractional bits, Q2.29 at the default) and an
// operation bit (0 sine, 1 cosine); each response transaction carries one result
// in the same format, in request order. The series has TERMS terms: odd powers
// for sine, even powers for cosine, each term derived from the last by a multiply
// with x^2 and a multiply with the fixed reciprocal of m*(m-1), both rounded to
// nearest with ties away from zero. Inner values saturate at +-(2^62 - 1) and the
// final sum is clamped to the 32-bit range. There is no range reduction, so large
// angles diverge and saturate. The pipeline takes one transaction per cycle while
// the skid register is empty. A three-stage partial-product multiplier forms x^2,
// every term adds two of them, then one stage finishes the sum and one output
// register drives the response. A skid register behind the output lets one more
// result land while the response side stalls; the request side stalls only while
// that skid register is occupied.
`include "assert_macros.svh"

module taylor_sine_cosine_unit
	import tsc_pkg::*;
#(
	parameter int TERMS = 11,
	parameter int FRACTION_BITS = 29
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      operation,
	input  logic signed [ANGLE_W-1:0] angle,
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output logic signed [ANGLE_W-1:0] value
);

	localparam int X2W = MAG_W + 1 - FRACTION_BITS;
	localparam int FSW = ANGLE_W + 2;
	localparam logic signed [SUM_W:0] VAL_MAX =
		$signed({{(SUM_W + 2 - ANGLE_W){1'b0}}, {(ANGLE_W - 1){1'b1}}});
	localparam logic signed [SUM_W:0] VAL_MIN = ~VAL_MAX;

	// global advance: the whole pipe moves unless the skid register is full
	logic en;

	// front end: |x| and x^2
	logic [ANGLE_W-1:0] x_mag;
	logic [FSW-1:0]     front_side;
	logic               x2_valid;
	logic [MAG_W-1:0]   x2_mag;
	logic [FSW-1:0]     x2_side;

	// term chain
	step_t          chain [TERMS];
	logic [X2W-1:0] x2_chain [TERMS];

	// closing stage
	logic signed [SUM_W:0]     fin_sum;
	logic signed [SUM_W:0]     fin_term;
	logic signed [SUM_W:0]     fin_total;
	logic signed [ANGLE_W-1:0] fin_value;
	logic                      res_valid_s1;
	logic signed [ANGLE_W-1:0] res_value_s1;

	// output register and skid register
	logic                      out_valid_q;
	logic signed [ANGLE_W-1:0] out_value_q;
	logic                      skid_full_q;
	logic signed [ANGLE_W-1:0] skid_value_q;

	assign en        = !skid_full_q;
	assign req_stall = skid_full_q;

	assign x_mag      = angle[ANGLE_W-1] ? $unsigned(-angle) : $unsigned(angle);
	assign front_side = {operation, angle[ANGLE_W-1], x_mag};

	tsc_mul #(
		.AW (ANGLE_W),
		.BW (ANGLE_W),
		.SH (FRACTION_BITS),
		.SW (FSW)
	) u_square (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (req_valid),
		.src_a     (x_mag),
		.src_b     (x_mag),
		.src_side  (front_side),
		.res_valid (x2_valid),
		.res_mag   (x2_mag),
		.res_side  (x2_side)
	);

	// seed the chain: first term is x for sine and 1.0 for cosine, sum starts at zero
	always_comb begin
		chain[0].valid  = x2_valid;
		chain[0].cosine = x2_side[FSW-1];
		chain[0].neg    = x2_side[FSW-1] ? 1'b0 : x2_side[FSW-2];
		chain[0].mag    = x2_side[FSW-1] ? (MAG_W'(1) << FRACTION_BITS)
		                                 : MAG_W'(x2_side[ANGLE_W-1:0]);
		chain[0].sum    = '0;
		x2_chain[0]     = x2_mag[X2W-1:0];
	end

	// each stage adds the term it receives and hands on the next one
	for (genvar k = 1; k < TERMS; k++) begin : g_term
		tsc_term #(
			.K             (k),
			.FRACTION_BITS (FRACTION_BITS)
		) u_term (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.src    (chain[k-1]),
			.src_x2 (x2_chain[k-1]),
			.dst    (chain[k]),
			.dst_x2 (x2_chain[k])
		);
	end

	// add the last term and clamp to the output word; inner saturation is
	// covered by the clamp since the 32-bit range lies well inside it
	always_comb begin
		fin_sum   = {chain[TERMS-1].sum[SUM_W-1], chain[TERMS-1].sum};
		fin_term  = chain[TERMS-1].neg ? -$signed({2'b00, chain[TERMS-1].mag})
		                               : $signed({2'b00, chain[TERMS-1].mag});
		fin_total = fin_sum + fin_term;
		if (fin_total > VAL_MAX) begin
			fin_value = VAL_MAX[ANGLE_W-1:0];
		end else if (fin_total < VAL_MIN) begin
			fin_value = VAL_MIN[ANGLE_W-1:0];
		end else begin
			fin_value = fin_total[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s1 <= 1'b0;
		end else if (en) begin
			res_valid_s1 <= chain[TERMS-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_value_s1 <= fin_value;
		end
	end

	// Output side. While the skid register is full the pipe holds; drain it
	// into the output register once the current result is taken. Otherwise a
	// result leaving the pipe goes to the output register if that is free or
	// being taken, and into the skid register if not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (!rsp_stall) begin
				skid_full_q <= 1'b0;
			end
		end else if (res_valid_s1) begin
			if (!out_valid_q || !rsp_stall) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_full_q <= 1'b1;
			end
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q) begin
			if (!rsp_stall) begin
				out_value_q <= skid_value_q;
			end
		end else if (res_valid_s1) begin
			if (!out_valid_q || !rsp_stall) begin
				out_value_q <= res_value_s1;
			end else begin
				skid_value_q <= res_value_s1;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign value     = out_value_q;

	// a held result in the skid register always sits behind a valid output
	`ASSERT_IMPLY(a_skid_behind_out, clk, arst_n, skid_full_q, out_valid_q)
	// the skid register fills only when the output was stalled
	`ASSERT_IMPLY(a_skid_fill_cause, clk, arst_n, $rose(skid_full_q), $past(out_valid_q && rsp_stall))
	// a result arriving at a stalled output is parked, not dropped
	`ASSERT_NEXT(a_park_result, clk, arst_n, res_valid_s1 && !skid_full_q && out_valid_q && rsp_stall, skid_full_q && $stable(out_value_q))
	// draining the skid register moves its result to the output
	`ASSERT_NEXT(a_skid_drain, clk, arst_n, skid_full_q && !rsp_stall, out_valid_q && out_value_q == $past(skid_value_q))

endmodule
